/* hdl/pnst_pkg.sv */
`default_nettype none

package pnst_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W = 16;   // input coordinates
  localparam int unsigned DIFF_W  = 17;   // coordinate differences
  localparam int unsigned PROD_W  = 34;   // 17x17 signed products
  localparam int unsigned LEN_W   = 33;   // squared length / remainder
  localparam int unsigned DOT_W   = 34;   // signed dot product
  localparam int unsigned SQ_W    = 32;   // one squared axis distance
  localparam int unsigned DIST_W  = 33;   // squared distance
  localparam int unsigned LIMIT_W = 32;   // near limit register

  localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST = LIMIT_W'(512);

  localparam int unsigned COORD_FRAC_BITS_DEF = 4;
  localparam int unsigned PROJ_FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    CLS_START,
    CLS_END,
    CLS_LERP
  } pnst_cls_e;

  // Per-item data carried alongside the arithmetic
  typedef struct packed {
    pnst_cls_e                  cls;
    logic signed [COORD_W-1:0]  sx;
    logic signed [COORD_W-1:0]  sy;
    logic signed [COORD_W-1:0]  ex;
    logic signed [COORD_W-1:0]  ey;
    logic signed [COORD_W-1:0]  qx;
    logic signed [COORD_W-1:0]  qy;
    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
  } pnst_side_t;

  typedef struct packed {
    logic                       is_near;
    logic signed [COORD_W-1:0]  closest_x;
    logic signed [COORD_W-1:0]  closest_y;
    logic [DIST_W-1:0]          dist_sq;
  } pnst_res_t;

endpackage

`default_nettype wire

/* hdl/pnst_in_if.sv */
`default_nettype none

interface pnst_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] seg_start_x;
  logic signed [15:0] seg_start_y;
  logic signed [15:0] seg_end_x;
  logic signed [15:0] seg_end_y;
  logic signed [15:0] query_x;
  logic signed [15:0] query_y;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/pnst_out_if.sv */
`default_nettype none

interface pnst_out_if;
  logic               valid;
  logic               ready;
  logic               is_near;
  logic signed [15:0] closest_x;
  logic signed [15:0] closest_y;
  logic [32:0]        dist_sq;

  modport source (
    output valid, is_near, closest_x, closest_y, dist_sq,
    input  ready
  );
  modport sink (
    input  valid, is_near, closest_x, closest_y, dist_sq,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/pnst_div.sv */
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// Expects rem < den; returns floor(rem * 2^PROJ_FRAC_BITS / den).
module pnst_div #(
  parameter int unsigned PROJ_FRAC_BITS = pnst_pkg::PROJ_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        in_valid_i,
  input  logic [pnst_pkg::LEN_W-1:0]  in_rem_i,
  input  logic [pnst_pkg::LEN_W-1:0]  in_den_i,
  input  pnst_pkg::pnst_side_t        in_side_i,
  output logic                        out_valid_o,
  output logic [PROJ_FRAC_BITS-1:0]   out_quot_o,
  output pnst_pkg::pnst_side_t        out_side_o
);
  import pnst_pkg::*;

  localparam int unsigned N = PROJ_FRAC_BITS;

  logic             v_q    [N];
  logic [LEN_W-1:0] rem_q  [N];
  logic [LEN_W-1:0] den_q  [N];
  logic [N-1:0]     quo_q  [N];
  pnst_side_t       side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             v_in;
    logic [LEN_W-1:0] rem_in;
    logic [LEN_W-1:0] den_in;
    logic [N-1:0]     quo_in;
    pnst_side_t       side_in;
    logic [LEN_W:0]   rem2;
    logic [LEN_W:0]   diff;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign rem_in  = in_rem_i;
      assign den_in  = in_den_i;
      assign quo_in  = '0;
      assign side_in = in_side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem2 = {rem_in, 1'b0};
    assign diff = rem2 - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // remainder stays below den, so the top bit of the kept value is dropped
        if (!diff[LEN_W]) begin
          rem_q[k] <= diff[LEN_W-1:0];
          quo_q[k] <= {quo_in[N-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem2[LEN_W-1:0];
          quo_q[k] <= {quo_in[N-2:0], 1'b0};
        end
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_quot_o  = quo_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule

`default_nettype wire

/* hdl/point_near_segment_test.sv */
`default_nettype none

// Closest point on a segment to a query point, with squared distance and a
// near flag. Coordinates are signed 16-bit fixed point (COORD_FRAC_BITS
// fraction bits). One item is accepted per cycle while in_i.ready is high.
// The output has a register plus a one-entry skid; while the skid holds an
// item the whole pipeline holds and in_i.ready is low. near_limit_q is
// written through cfg_we_i/cfg_wdata_i and should only change with the
// pipeline empty.
module point_near_segment_test #(
  parameter int unsigned COORD_FRAC_BITS = pnst_pkg::COORD_FRAC_BITS_DEF,
  parameter int unsigned PROJ_FRAC_BITS  = pnst_pkg::PROJ_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pnst_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  pnst_in_if.sink                       in_i,
  pnst_out_if.source                    out_o
);
  import pnst_pkg::*;

  // lerp product: (P+1)-bit unsigned t times 17-bit signed delta
  localparam int unsigned PRW = PROJ_FRAC_BITS + DIFF_W + 1;
  localparam logic [LEN_W-1:0] MIN_LEN2 = LEN_W'(1) << (2 * COORD_FRAC_BITS);
  // bias that turns the arithmetic shift into truncation toward zero
  localparam logic signed [PRW-1:0] RND =
    {{(PRW - PROJ_FRAC_BITS){1'b0}}, {PROJ_FRAC_BITS{1'b1}}};

  // ---------------------------------------------------------------------
  // Flow control: every stage advances together unless the skid is full.
  // ---------------------------------------------------------------------
  logic en;
  logic skid_v_q;
  logic out_v_q;

  assign en         = !skid_v_q;
  assign in_i.ready = en;

  // ---------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------
  logic [LIMIT_W-1:0] near_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q <= NEAR_LIMIT_RST;
    end else if (cfg_we_i) begin
      near_limit_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: deltas (segment direction and query offset)
  // ---------------------------------------------------------------------
  logic                     v1_q;
  logic signed [DIFF_W-1:0] rx1_q, ry1_q;
  pnst_side_t               side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q.cls <= CLS_START;
      side1_q.sx  <= in_i.seg_start_x;
      side1_q.sy  <= in_i.seg_start_y;
      side1_q.ex  <= in_i.seg_end_x;
      side1_q.ey  <= in_i.seg_end_y;
      side1_q.qx  <= in_i.query_x;
      side1_q.qy  <= in_i.query_y;
      side1_q.dx  <= {in_i.seg_end_x[15], in_i.seg_end_x}
                   - {in_i.seg_start_x[15], in_i.seg_start_x};
      side1_q.dy  <= {in_i.seg_end_y[15], in_i.seg_end_y}
                   - {in_i.seg_start_y[15], in_i.seg_start_y};
      rx1_q       <= {in_i.query_x[15], in_i.query_x}
                   - {in_i.seg_start_x[15], in_i.seg_start_x};
      ry1_q       <= {in_i.query_y[15], in_i.query_y}
                   - {in_i.seg_start_y[15], in_i.seg_start_y};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: four 17x17 products
  // ---------------------------------------------------------------------
  logic                     v2_q;
  logic signed [PROD_W-1:0] dxx2_q, dyy2_q, rxdx2_q, rydy2_q;
  pnst_side_t               side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dxx2_q  <= side1_q.dx * side1_q.dx;
      dyy2_q  <= side1_q.dy * side1_q.dy;
      rxdx2_q <= rx1_q * side1_q.dx;
      rydy2_q <= ry1_q * side1_q.dy;
      side2_q <= side1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: squared length and dot product
  // ---------------------------------------------------------------------
  logic                    v3_q;
  logic [LEN_W-1:0]        len2_3_q;
  logic signed [DOT_W-1:0] dot3_q;
  pnst_side_t              side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // squares are below 2^32, so the low 32 bits are the whole value
      len2_3_q <= {1'b0, dxx2_q[SQ_W-1:0]} + {1'b0, dyy2_q[SQ_W-1:0]};
      dot3_q   <= rxdx2_q + rydy2_q;
      side3_q  <= side2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: classify (short / before start / past end / inside)
  // ---------------------------------------------------------------------
  logic       seg_short, dot_le_zero, dot_past;
  pnst_cls_e  cls3;
  pnst_side_t side4_d;

  assign seg_short   = len2_3_q < MIN_LEN2;
  assign dot_le_zero = dot3_q[DOT_W-1] || (dot3_q == '0);
  assign dot_past    = dot3_q >= $signed({1'b0, len2_3_q});

  always_comb begin
    if (seg_short || dot_le_zero) begin
      cls3 = CLS_START;
    end else if (dot_past) begin
      cls3 = CLS_END;
    end else begin
      cls3 = CLS_LERP;
    end
  end

  always_comb begin
    side4_d     = side3_q;
    side4_d.cls = cls3;
  end

  logic             v4_q;
  logic [LEN_W-1:0] rem4_q, den4_q;
  pnst_side_t       side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // only an inside item needs a real quotient; others divide zero
      rem4_q  <= (cls3 == CLS_LERP) ? dot3_q[LEN_W-1:0] : '0;
      den4_q  <= len2_3_q;
      side4_q <= side4_d;
    end
  end

  // ---------------------------------------------------------------------
  // Projection t = dot * 2^P / len2, one bit per stage
  // ---------------------------------------------------------------------
  logic                      dv_valid;
  logic [PROJ_FRAC_BITS-1:0] dv_quot;
  pnst_side_t                dv_side;

  pnst_div #(
    .PROJ_FRAC_BITS (PROJ_FRAC_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (v4_q),
    .in_rem_i    (rem4_q),
    .in_den_i    (den4_q),
    .in_side_i   (side4_q),
    .out_valid_o (dv_valid),
    .out_quot_o  (dv_quot),
    .out_side_o  (dv_side)
  );

  // ---------------------------------------------------------------------
  // Stage 5: t * delta on each axis
  // ---------------------------------------------------------------------
  logic                  v5_q;
  logic signed [PRW-1:0] px5_q, py5_q;
  pnst_side_t            side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px5_q   <= $signed({1'b0, dv_quot}) * dv_side.dx;
      py5_q   <= $signed({1'b0, dv_quot}) * dv_side.dy;
      side5_q <= dv_side;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: closest point
  // ---------------------------------------------------------------------
  logic signed [PRW-1:0]     adj_x, adj_y, sh_x, sh_y;
  logic [DIFF_W-1:0]         sum_x, sum_y;
  logic signed [COORD_W-1:0] cx5, cy5;

  assign adj_x = px5_q + (px5_q[PRW-1] ? RND : '0);
  assign adj_y = py5_q + (py5_q[PRW-1] ? RND : '0);
  assign sh_x  = adj_x >>> PROJ_FRAC_BITS;
  assign sh_y  = adj_y >>> PROJ_FRAC_BITS;
  // offset magnitude never exceeds |delta|, so 17 bits hold it
  assign sum_x = {side5_q.sx[COORD_W-1], side5_q.sx} + sh_x[DIFF_W-1:0];
  assign sum_y = {side5_q.sy[COORD_W-1], side5_q.sy} + sh_y[DIFF_W-1:0];

  always_comb begin
    case (side5_q.cls)
      CLS_END: begin
        cx5 = side5_q.ex;
        cy5 = side5_q.ey;
      end
      CLS_LERP: begin
        cx5 = sum_x[COORD_W-1:0];
        cy5 = sum_y[COORD_W-1:0];
      end
      default: begin
        cx5 = side5_q.sx;
        cy5 = side5_q.sy;
      end
    endcase
  end

  logic                      v6_q;
  logic signed [COORD_W-1:0] cx6_q, cy6_q;
  pnst_side_t                side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx6_q   <= cx5;
      cy6_q   <= cy5;
      side6_q <= side5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: offset from query to closest point
  // ---------------------------------------------------------------------
  logic                      v7_q;
  logic signed [DIFF_W-1:0]  ddx7_q, ddy7_q;
  logic signed [COORD_W-1:0] cx7_q, cy7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ddx7_q <= {cx6_q[COORD_W-1], cx6_q} - {side6_q.qx[COORD_W-1], side6_q.qx};
      ddy7_q <= {cy6_q[COORD_W-1], cy6_q} - {side6_q.qy[COORD_W-1], side6_q.qy};
      cx7_q  <= cx6_q;
      cy7_q  <= cy6_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 8: squares
  // ---------------------------------------------------------------------
  logic                      v8_q;
  logic [SQ_W-1:0]           sqx8_q, sqy8_q;
  logic signed [COORD_W-1:0] cx8_q, cy8_q;
  logic signed [PROD_W-1:0]  sqx7, sqy7;

  assign sqx7 = ddx7_q * ddx7_q;
  assign sqy7 = ddy7_q * ddy7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en) begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx8_q <= sqx7[SQ_W-1:0];
      sqy8_q <= sqy7[SQ_W-1:0];
      cx8_q  <= cx7_q;
      cy8_q  <= cy7_q;
    end
  end

  // ---------------------------------------------------------------------
  // Result: distance sum, near compare, output register and skid
  // ---------------------------------------------------------------------
  pnst_res_t res8, out_q, skid_q;
  logic      out_take, out_hold;

  always_comb begin
    res8.dist_sq   = {1'b0, sqx8_q} + {1'b0, sqy8_q};
    res8.is_near   = res8.dist_sq < {1'b0, near_limit_q};
    res8.closest_x = cx8_q;
    res8.closest_y = cy8_q;
  end

  assign out_take = out_v_q && out_o.ready;
  assign out_hold = out_v_q && !out_o.ready;

  // skid only fills when the output register is held; the pipe then stops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        skid_v_q <= 1'b0;
      end
    end else if (v8_q) begin
      if (out_hold) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (v8_q) begin
      if (out_hold) begin
        skid_q <= res8;
      end else begin
        out_q <= res8;
      end
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.is_near   = out_q.is_near;
  assign out_o.closest_x = out_q.closest_x;
  assign out_o.closest_y = out_q.closest_y;
  assign out_o.dist_sq   = out_q.dist_sq;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // skid never holds an item unless the output register holds one too
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid valid while output register empty");

  // skid fills only after the output was stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid filled without an output stall");

  // closest point stays inside the segment's bounding box
  a_bbox: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |->
      ((cx6_q >= side6_q.sx && cx6_q <= side6_q.ex) ||
       (cx6_q <= side6_q.sx && cx6_q >= side6_q.ex)) &&
      ((cy6_q >= side6_q.sy && cy6_q <= side6_q.ey) ||
       (cy6_q <= side6_q.sy && cy6_q >= side6_q.ey)))
    else $error("closest point outside segment bounding box");

endmodule

`default_nettype wire
